// ----- rtl/tpsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsv_pkg
// Types and constants shared by the token-pack stream validator.
// ----------------------------------------------------------------------------
package tpsv_pkg;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 136;   // 4 + 64 + 64 = 132, padded to bytes
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOCAB   = 2'd2;

    localparam logic [31:0] RST_MAGIC   = 32'd0;
    localparam logic [31:0] RST_VERSION = 32'd1;
    localparam logic [32:0] RST_VOCAB   = 33'd65536;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] HDR_LEN   = 32'd64;

    localparam int NUM_CHK = 11;

    localparam logic [3:0] ERR_OK       = 4'd0;
    localparam logic [3:0] ERR_SHORT    = 4'd1;
    localparam logic [3:0] ERR_MAGIC    = 4'd2;
    localparam logic [3:0] ERR_VERSION  = 4'd3;
    localparam logic [3:0] ERR_HDRLEN   = 4'd4;
    localparam logic [3:0] ERR_FLAGS    = 4'd5;
    localparam logic [3:0] ERR_RESV     = 4'd6;
    localparam logic [3:0] ERR_TABOFF   = 4'd7;
    localparam logic [3:0] ERR_LENGTH   = 4'd8;
    localparam logic [3:0] ERR_OFFTAB   = 4'd9;
    localparam logic [3:0] ERR_CHECKSUM = 4'd10;
    localparam logic [3:0] ERR_TOKEN    = 4'd11;

    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] version;
        logic [32:0] vocab;
    } t_cfg;

    typedef struct packed {
        logic        valid_res;
        logic [3:0]  error_code;
        logic [63:0] seq_count;
        logic [63:0] token_count;
    } t_res;

endpackage

// ----- rtl/tpsv_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsv_cfg
// Configuration registers: magic word, format version, vocabulary limit.
// ----------------------------------------------------------------------------
module tpsv_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tpsv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tpsv_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tpsv_pkg::t_cfg                   o_cfg
);
    import tpsv_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic   <= RST_MAGIC;
            r_cfg.version <= RST_VERSION;
            r_cfg.vocab   <= RST_VOCAB;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_cfg.magic   <= i_cfg_data[31:0];
                CFG_VERSION: r_cfg.version <= i_cfg_data[31:0];
                CFG_VOCAB:   r_cfg.vocab   <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/tpsv_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsv_core
// Input register and per-byte check logic: header capture, FNV-1a hash,
// token range, offset table and final length / checksum verdict.
// ----------------------------------------------------------------------------
module tpsv_core #(
    parameter int FILE_LEN_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tpsv_pkg::t_cfg                   i_cfg,
    input  logic                             i_tvalid,
    output logic                             o_tready,
    input  logic [tpsv_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  logic                             i_tlast,
    input  logic                             i_out_free,
    output logic                             o_res_vld,
    output tpsv_pkg::t_res                   o_res
);
    import tpsv_pkg::*;

    localparam logic [FILE_LEN_BITS-1:0] POS_MAX = '1;

    localparam logic [5:0] HP_VERSION = 6'd7;
    localparam logic [5:0] HP_HDRLEN  = 6'd11;
    localparam logic [5:0] HP_FLAGS   = 6'd15;
    localparam logic [5:0] HP_SEQ     = 6'd23;
    localparam logic [5:0] HP_TOK     = 6'd31;
    localparam logic [5:0] HP_OFF     = 6'd39;
    localparam logic [5:0] HP_LAYOUT  = 6'd40;
    localparam logic [5:0] HP_EXPLEN  = 6'd41;
    localparam logic [5:0] HP_CHK     = 6'd43;
    localparam logic [5:0] HP_RESV    = 6'd44;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       adv;

    // per-file state
    logic [FILE_LEN_BITS-1:0] r_pos, n_pos;
    logic [63:0] r_seq, n_seq;
    logic [63:0] r_tok, n_tok;
    logic [63:0] r_off, n_off;
    logic [31:0] r_chk, n_chk;
    logic [31:0] r_hash, n_hash;
    logic [63:0] r_wa, n_wa;
    logic [63:0] r_prev, n_prev;
    logic [NUM_CHK-1:0] r_flags, n_flags;
    logic [63:0] r_tab, n_tab;
    logic        r_seq_bad, n_seq_bad;
    logic [63:0] r_exp_len, n_exp_len;
    logic        r_len_bad, n_len_bad;

    logic [NUM_CHK-1:0] fl;
    logic [31:0] w32;
    logic        in_hdr;
    logic [5:0]  hp;
    logic [63:0] pw;
    logic [63:0] diff;
    logic [63:0] len64;
    logic [64:0] s7;
    logic [64:0] s8;
    logic [3:0]  code;
    t_res        res;

    assign adv      = r_in_vld && (!r_in_last || i_out_free);
    assign o_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_tready) begin
            r_in_vld <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_in_byte <= i_tdata;
            r_in_last <= i_tlast;
        end
    end

    always_comb begin
        n_wa      = {r_in_byte, r_wa[63:8]};
        w32       = n_wa[63:32];
        n_pos     = (r_pos == POS_MAX) ? r_pos : FILE_LEN_BITS'(r_pos + 1'b1);
        n_seq     = r_seq;
        n_tok     = r_tok;
        n_off     = r_off;
        n_chk     = r_chk;
        n_hash    = r_hash;
        n_prev    = r_prev;
        n_tab     = r_tab;
        n_seq_bad = r_seq_bad;
        n_exp_len = r_exp_len;
        n_len_bad = r_len_bad;
        fl        = '0;
        in_hdr    = (r_pos[FILE_LEN_BITS-1:6] == '0);
        hp        = r_pos[5:0];
        pw        = 64'(r_pos);
        diff      = pw - r_off;
        len64     = 64'(n_pos);
        s7        = {1'b0, r_tok[61:0], 2'b00} + 65'd64;
        s8        = {1'b0, r_off} + {1'b0, r_tab};

        if (in_hdr) begin
            if (hp < 6'd4) begin
                if (r_in_byte != i_cfg.magic[{hp[1:0], 3'b000} +: 8])
                    fl[ERR_MAGIC-1] = 1'b1;
            end else if (hp == HP_VERSION) begin
                if (w32 != i_cfg.version) fl[ERR_VERSION-1] = 1'b1;
            end else if (hp == HP_HDRLEN) begin
                if (w32 != HDR_LEN) fl[ERR_HDRLEN-1] = 1'b1;
            end else if (hp == HP_FLAGS) begin
                if (w32 != 32'd0) fl[ERR_FLAGS-1] = 1'b1;
            end else if (hp == HP_SEQ) begin
                n_seq = n_wa;
            end else if (hp == HP_TOK) begin
                n_tok = n_wa;
            end else if (hp == HP_OFF) begin
                n_off = n_wa;
            end else if (hp == HP_LAYOUT) begin
                // table offset must be 64 + 4 * tokens, no overflow
                if ((r_tok[63:62] != 2'd0) || s7[64] || (r_off != s7[63:0]))
                    fl[ERR_TABOFF-1] = 1'b1;
                n_tab     = {61'(r_seq[60:0] + 61'd1), 3'b000};
                n_seq_bad = (r_seq[63:61] != 3'd0) || (&r_seq[60:0]);
            end else if (hp == HP_EXPLEN) begin
                n_exp_len = s8[63:0];
                n_len_bad = r_seq_bad || s8[64];
            end else if (hp == HP_CHK) begin
                n_chk = w32;
            end else if (hp >= HP_RESV) begin
                if (r_in_byte != 8'd0) fl[ERR_RESV-1] = 1'b1;
            end
        end else begin
            n_hash = (r_hash ^ {24'd0, r_in_byte}) * FNV_PRIME;
            if (pw < r_off) begin
                if (r_pos[1:0] == 2'b11) begin
                    if ({1'b0, w32} >= i_cfg.vocab) fl[ERR_TOKEN-1] = 1'b1;
                end
            end else if (diff[2:0] == 3'b111) begin
                if (diff[63:3] == 61'd0) begin
                    if (n_wa != 64'd0) fl[ERR_OFFTAB-1] = 1'b1;
                end else if ((n_wa < r_prev) || (n_wa > r_tok)) begin
                    fl[ERR_OFFTAB-1] = 1'b1;
                end
                n_prev = n_wa;
            end
        end

        if (r_in_last) begin
            if (len64 < 64'(HDR_LEN)) begin
                fl[ERR_SHORT-1] = 1'b1;
            end else begin
                if (r_len_bad || (len64 != r_exp_len) || (n_pos == POS_MAX))
                    fl[ERR_LENGTH-1] = 1'b1;
                if (n_prev != r_tok) fl[ERR_OFFTAB-1] = 1'b1;
                if (n_hash != r_chk) fl[ERR_CHECKSUM-1] = 1'b1;
            end
        end

        n_flags = r_flags | fl;
        code    = ERR_OK;
        for (int k = NUM_CHK - 1; k >= 0; k--) begin
            if (n_flags[k]) code = 4'(k + 1);
        end

        res.valid_res   = (code == ERR_OK);
        res.error_code  = code;
        res.seq_count   = n_seq;
        res.token_count = n_tok;

        // verdict closes the file
        if (r_in_last) begin
            n_pos   = '0;
            n_seq   = '0;
            n_tok   = '0;
            n_hash  = FNV_BASIS;
            n_prev  = '0;
            n_flags = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_seq   <= '0;
            r_tok   <= '0;
            r_hash  <= FNV_BASIS;
            r_prev  <= '0;
            r_flags <= '0;
        end else if (adv) begin
            r_pos   <= n_pos;
            r_seq   <= n_seq;
            r_tok   <= n_tok;
            r_hash  <= n_hash;
            r_prev  <= n_prev;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wa      <= n_wa;
            r_off     <= n_off;
            r_chk     <= n_chk;
            r_tab     <= n_tab;
            r_seq_bad <= n_seq_bad;
            r_exp_len <= n_exp_len;
            r_len_bad <= n_len_bad;
        end
    end

    assign o_res_vld = adv && r_in_last;
    assign o_res     = res;

endmodule

// ----- rtl/tpsv_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsv_out
// Result register on the master side; holds one verdict until taken.
// ----------------------------------------------------------------------------
module tpsv_out (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_res_vld,
    input  tpsv_pkg::t_res  i_res,
    output logic            o_free,
    output logic            o_tvalid,
    input  logic            i_tready,
    output tpsv_pkg::t_res  o_res
);
    import tpsv_pkg::*;

    logic r_vld;
    t_res r_res;

    assign o_free   = !r_vld || i_tready;
    assign o_tvalid = r_vld;
    assign o_res    = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res_vld) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- rtl/token_pack_stream_validator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_pack_stream_validator_unit
// Streaming validator for token-pack files, one byte per request.
// ----------------------------------------------------------------------------
// The file enters one byte per cycle on the slave side, tlast on its final
// byte. Each byte is registered, then checked in one pass of logic whose
// critical path is the 32x32 FNV multiply and the 64-bit offset compares.
// Bytes flow at one per cycle with no bubbles; only the last byte of a file
// waits while the previous verdict still sits unread in the result register.
// The verdict is formed as the last byte leaves the input register and is then
// held in the result register: tuser carries the pass flag, tdata the error
// code and the header's sequence and token counts. Configuration writes are
// taken in any cycle and are meant for use between files.
module token_pack_stream_validator_unit #(
    parameter int FILE_LEN_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tpsv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tpsv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tpsv_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic                              s_axis_tlast,   // last_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] error_code, [67:4] seq_count, [131:68] token_count, [135:132] zero
    output logic [tpsv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tuser    // [0] valid_res
);
    import tpsv_pkg::*;

    t_cfg cfg;
    t_res core_res;
    t_res out_res;
    logic core_res_vld;
    logic out_free;

    tpsv_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tpsv_core #(
        .FILE_LEN_BITS (FILE_LEN_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_tvalid   (s_axis_tvalid),
        .o_tready   (s_axis_tready),
        .i_tdata    (s_axis_tdata),
        .i_tlast    (s_axis_tlast),
        .i_out_free (out_free),
        .o_res_vld  (core_res_vld),
        .o_res      (core_res)
    );

    tpsv_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res_vld (core_res_vld),
        .i_res     (core_res),
        .o_free    (out_free),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_res     (out_res)
    );

    assign m_axis_tdata = {4'd0, out_res.token_count, out_res.seq_count, out_res.error_code};
    assign m_axis_tuser = out_res.valid_res;

endmodule

// ----- rtl/tpsv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpsv_checker
// Port-level checks on the validator's result channel.
// ----------------------------------------------------------------------------
module tpsv_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [tpsv_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              m_axis_tuser
);
    import tpsv_pkg::*;

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_pass_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[3:0] == ERR_OK)))
        else $error("pass flag disagrees with error code");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= ERR_TOKEN))
        else $error("error code out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind token_pack_stream_validator_unit tpsv_checker u_tpsv_checker (.*);
